FILE: rtl/pmp_pkg.sv
// shared types, constants and state encoding for the envelope anticorrelation pump detector
// no dependencies; imported by every module of the block
package pmp_pkg;

    localparam int WINDOW_LENGTH = 64;
    localparam int AW            = $clog2(WINDOW_LENGTH);
    localparam int EW            = 16;
    localparam int SW            = EW + AW;
    localparam int QW            = 2 * EW + AW;
    localparam int VW            = 2 * EW + 2 * AW;
    localparam int DW            = 2 * VW;
    localparam int PW            = DW + 32;
    localparam int CNTW          = $clog2(VW + 1);
    localparam int SMW           = EW + 2;
    localparam int Q_BITS        = 16;
    localparam int BITW          = $clog2(Q_BITS);
    localparam int Q_FRAC        = 15;
    localparam int ONE_Q15       = 32768;
    localparam int SCALE_SHIFT   = 30;
    localparam int CFG_IDX_W     = 1;
    localparam int CFG_DW        = 16;

    localparam logic [CFG_DW-1:0] ATTACK_RESET  = 16'd4915;
    localparam logic [CFG_DW-1:0] RELEASE_RESET = 16'd1638;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_ATTACK  = 1'b0,
        REG_RELEASE = 1'b1
    } cfg_reg_t;

    typedef struct packed {
        logic [EW-1:0] bass_energy;
        logic [EW-1:0] mid_energy;
    } in_item_t;

    typedef struct packed {
        logic [15:0] pump_level;
        logic        window_full;
    } out_item_t;

    typedef struct packed {
        logic          start;
        logic [DW-1:0] mcand;
        logic [VW-1:0] mplier;
    } mul_cmd_t;

    typedef enum logic [4:0] {
        S_IDLE,
        S_W_LOAD,
        S_W_BB,
        S_W_MM,
        S_W_BM,
        S_W_ACC,
        S_MWAIT,
        S_G_SB,
        S_G_SM,
        S_G_CR,
        S_G_D,
        S_G_C,
        S_T_SQ,
        S_T_LAUNCH,
        S_G_T,
        S_SM_MUL,
        S_SM_UPD,
        S_OUT
    } state_t;

endpackage

FILE: rtl/pmp_ring.sv
// envelope window store: bass and mid values side by side, one write and one read port
// read data registered; depends on pmp_pkg
module pmp_ring (
    input  logic                   clk,
    input  logic                   wr_en,
    input  logic [pmp_pkg::AW-1:0] wr_addr,
    input  pmp_pkg::in_item_t      wr_item,
    input  logic [pmp_pkg::AW-1:0] rd_addr,
    output pmp_pkg::in_item_t      rd_item
);
    import pmp_pkg::*;

    in_item_t mem [WINDOW_LENGTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_item;
        end
        rd_item <= mem[rd_addr];
    end

endmodule

FILE: rtl/pmp_smul.sv
// shared shift-add multiplier, one multiplier bit per cycle
// depends on pmp_pkg
module pmp_smul (
    input  logic                   clk,
    input  logic                   rst_n,
    input  pmp_pkg::mul_cmd_t      cmd,
    output logic                   done,
    output logic [pmp_pkg::PW-1:0] product
);
    import pmp_pkg::*;

    logic [PW-1:0]   acc_reg, acc_next;
    logic [PW-1:0]   mcand_reg, mcand_next;
    logic [VW-1:0]   mplier_reg, mplier_next;
    logic [CNTW-1:0] cnt_reg, cnt_next;
    logic            busy_reg, busy_next;
    logic            done_reg, done_next;

    always_comb
    begin
        acc_next    = acc_reg;
        mcand_next  = mcand_reg;
        mplier_next = mplier_reg;
        cnt_next    = cnt_reg;
        busy_next   = busy_reg;
        done_next   = 1'b0;
        priority if (cmd.start)
        begin
            acc_next    = '0;
            mcand_next  = PW'(cmd.mcand);
            mplier_next = cmd.mplier;
            cnt_next    = CNTW'(VW);
            busy_next   = 1'b1;
        end
        else if (busy_reg)
        begin
            if (mplier_reg[0])
            begin
                acc_next = acc_reg + mcand_reg;
            end
            mcand_next  = mcand_reg << 1;
            mplier_next = mplier_reg >> 1;
            cnt_next    = cnt_reg - CNTW'(1);
            if (cnt_reg == CNTW'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        acc_reg    <= acc_next;
        mcand_reg  <= mcand_next;
        mplier_reg <= mplier_next;
    end

    assign done    = done_reg;
    assign product = acc_reg;

endmodule

FILE: rtl/envelope_anticorrelation_pump_detector.sv
// while the window fills, a request goes straight to the output; once it is full, each
// request walks the N stored pairs through S_W_LOAD, S_W_BB, S_W_MM, S_W_BM and S_W_ACC
// on one small multiplier, then the bit-serial wide multiplier (VW = 32 + 2*log2 N bits)
// one request at a time; ready again as soon as the result is placed in the output register
// asynchronous active-low reset clears control, gains to defaults, window empty, level zero
module envelope_anticorrelation_pump_detector (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  pmp_pkg::in_item_t             in_data,
    output logic                          out_valid,
    input  logic                          out_ready,
    output pmp_pkg::out_item_t            out_data,
    input  logic                          cfg_write,
    input  logic [pmp_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [pmp_pkg::CFG_DW-1:0]    cfg_data
);
    import pmp_pkg::*;

    state_t          state_reg, state_next, ret_reg, ret_next;
    logic [AW-1:0]   slot_reg, slot_next, idx_reg, idx_next;
    logic            filled_reg, filled_next;
    logic [15:0]     smooth_reg, smooth_next;
    logic [15:0]     attack_reg, attack_next, release_reg, release_next;
    logic [SW-1:0]   sb_reg, sb_next, sm_reg, sm_next;
    logic [QW-1:0]   sbb_reg, sbb_next, smm_reg, smm_next, sbm_reg, sbm_next;
    logic [VW-1:0]   varb_reg, varb_next, varm_reg, varm_next, mag_reg, mag_next;
    logic [DW-1:0]   d_reg, d_next, c_reg, c_next;
    logic [BITW-1:0] bit_reg, bit_next;
    logic [15:0]     q_reg, q_next;
    logic signed [2*SMW-1:0] prod_reg, prod_next;
    logic            out_valid_reg, out_valid_next;
    out_item_t       out_data_reg, out_data_next;

    logic                  accept;
    logic                  slot_last, idx_last;
    in_item_t              rd_item;
    mul_cmd_t              mul_cmd;
    logic                  mul_done;
    logic [PW-1:0]         mul_prod;
    logic signed [SMW-1:0] op_a, op_b;
    logic signed [VW:0]    cov_w;
    logic [15:0]           t_w;
    logic [PW-1:0]         rhs_w;
    logic signed [2*SMW-1:0] step_w, sum_w;

    pmp_ring u_ring (
        .clk     (clk),
        .wr_en   (accept),
        .wr_addr (slot_reg),
        .wr_item (in_data),
        .rd_addr (idx_reg),
        .rd_item (rd_item)
    );

    pmp_smul u_smul (
        .clk     (clk),
        .rst_n   (rst_n),
        .cmd     (mul_cmd),
        .done    (mul_done),
        .product (mul_prod)
    );

    assign in_ready  = (state_reg == S_IDLE);
    assign accept    = in_valid && in_ready;
    assign slot_last = (slot_reg == AW'(WINDOW_LENGTH - 1));
    assign idx_last  = (idx_reg == AW'(WINDOW_LENGTH - 1));
    assign t_w       = q_reg | (16'd1 << bit_reg);
    assign rhs_w     = PW'(c_reg) << SCALE_SHIFT;
    assign cov_w     = $signed({1'b0, VW'(sbm_reg) * VW'(WINDOW_LENGTH)})
                     - $signed({1'b0, mul_prod[VW-1:0]});
    assign step_w    = prod_reg >>> Q_FRAC;
    assign sum_w     = step_w + $signed({{(2*SMW-16){1'b0}}, smooth_reg});
    assign prod_next = op_a * op_b;

    // next state
    always_comb
    begin
        state_next = state_reg;
        ret_next   = ret_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    state_next = (filled_reg || slot_last) ? S_W_LOAD : S_OUT;
                end
            end
            S_W_LOAD:   state_next = S_W_BB;
            S_W_BB:     state_next = S_W_MM;
            S_W_MM:     state_next = S_W_BM;
            S_W_BM:     state_next = S_W_ACC;
            S_W_ACC:
            begin
                if (idx_last)
                begin
                    state_next = S_MWAIT;
                    ret_next   = S_G_SB;
                end
                else
                begin
                    state_next = S_W_LOAD;
                end
            end
            S_MWAIT:
            begin
                if (mul_done)
                begin
                    state_next = ret_reg;
                end
            end
            S_G_SB:
            begin
                state_next = S_MWAIT;
                ret_next   = S_G_SM;
            end
            S_G_SM:
            begin
                state_next = S_MWAIT;
                ret_next   = S_G_CR;
            end
            S_G_CR:
            begin
                priority if (varb_reg == '0 || varm_reg == '0)
                begin
                    state_next = S_OUT;
                end
                else if (!cov_w[VW])
                begin
                    state_next = S_SM_MUL;
                end
                else
                begin
                    state_next = S_MWAIT;
                    ret_next   = S_G_D;
                end
            end
            S_G_D:
            begin
                state_next = S_MWAIT;
                ret_next   = S_G_C;
            end
            S_G_C:      state_next = S_T_SQ;
            S_T_SQ:     state_next = S_T_LAUNCH;
            S_T_LAUNCH:
            begin
                state_next = S_MWAIT;
                ret_next   = S_G_T;
            end
            S_G_T:      state_next = (bit_reg == '0) ? S_SM_MUL : S_T_SQ;
            S_SM_MUL:   state_next = S_SM_UPD;
            S_SM_UPD:   state_next = S_OUT;
            S_OUT:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    state_next = S_IDLE;
                end
            end
            default:    state_next = S_IDLE;
        endcase
    end

    // datapath and outputs
    always_comb
    begin
        slot_next      = slot_reg;
        filled_next    = filled_reg;
        idx_next       = idx_reg;
        smooth_next    = smooth_reg;
        attack_next    = attack_reg;
        release_next   = release_reg;
        sb_next        = sb_reg;
        sm_next        = sm_reg;
        sbb_next       = sbb_reg;
        smm_next       = smm_reg;
        sbm_next       = sbm_reg;
        varb_next      = varb_reg;
        varm_next      = varm_reg;
        mag_next       = mag_reg;
        d_next         = d_reg;
        c_next         = c_reg;
        bit_next       = bit_reg;
        q_next         = q_reg;
        out_valid_next = out_valid_reg && !out_ready;
        out_data_next  = out_data_reg;
        mul_cmd        = '0;
        op_a           = '0;
        op_b           = '0;

        if (cfg_write)
        begin
            unique case (cfg_reg_t'(cfg_index))
                REG_ATTACK:  attack_next  = cfg_data;
                REG_RELEASE: release_next = cfg_data;
                default:     attack_next  = attack_reg;
            endcase
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    slot_next   = slot_last ? '0 : slot_reg + AW'(1);
                    filled_next = filled_reg || slot_last;
                    idx_next    = '0;
                    sb_next     = '0;
                    sm_next     = '0;
                    sbb_next    = '0;
                    smm_next    = '0;
                    sbm_next    = '0;
                end
            end
            S_W_BB:
            begin
                op_a    = $signed({2'b00, rd_item.bass_energy});
                op_b    = $signed({2'b00, rd_item.bass_energy});
                sb_next = sb_reg + SW'(rd_item.bass_energy);
                sm_next = sm_reg + SW'(rd_item.mid_energy);
            end
            S_W_MM:
            begin
                op_a     = $signed({2'b00, rd_item.mid_energy});
                op_b     = $signed({2'b00, rd_item.mid_energy});
                sbb_next = sbb_reg + QW'(prod_reg[2*EW-1:0]);
            end
            S_W_BM:
            begin
                op_a     = $signed({2'b00, rd_item.bass_energy});
                op_b     = $signed({2'b00, rd_item.mid_energy});
                smm_next = smm_reg + QW'(prod_reg[2*EW-1:0]);
            end
            S_W_ACC:
            begin
                sbm_next = sbm_reg + QW'(prod_reg[2*EW-1:0]);
                idx_next = idx_reg + AW'(1);
                if (idx_last)
                begin
                    mul_cmd.start  = 1'b1;
                    mul_cmd.mcand  = DW'(sb_reg);
                    mul_cmd.mplier = VW'(sb_reg);
                end
            end
            S_G_SB:
            begin
                varb_next      = VW'(sbb_reg) * VW'(WINDOW_LENGTH) - mul_prod[VW-1:0];
                mul_cmd.start  = 1'b1;
                mul_cmd.mcand  = DW'(sm_reg);
                mul_cmd.mplier = VW'(sm_reg);
            end
            S_G_SM:
            begin
                varm_next      = VW'(smm_reg) * VW'(WINDOW_LENGTH) - mul_prod[VW-1:0];
                mul_cmd.start  = 1'b1;
                mul_cmd.mcand  = DW'(sb_reg);
                mul_cmd.mplier = VW'(sm_reg);
            end
            S_G_CR:
            begin
                mag_next = VW'(-cov_w);
                q_next   = '0;
                if (varb_reg != '0 && varm_reg != '0 && cov_w[VW])
                begin
                    mul_cmd.start  = 1'b1;
                    mul_cmd.mcand  = DW'(varb_reg);
                    mul_cmd.mplier = varm_reg;
                end
            end
            S_G_D:
            begin
                d_next         = mul_prod[DW-1:0];
                mul_cmd.start  = 1'b1;
                mul_cmd.mcand  = DW'(mag_reg);
                mul_cmd.mplier = mag_reg;
            end
            S_G_C:
            begin
                c_next   = mul_prod[DW-1:0];
                bit_next = BITW'(Q_BITS - 1);
                q_next   = '0;
            end
            S_T_SQ:
            begin
                op_a = $signed({2'b00, t_w});
                op_b = $signed({2'b00, t_w});
            end
            S_T_LAUNCH:
            begin
                mul_cmd.start  = 1'b1;
                mul_cmd.mcand  = d_reg;
                mul_cmd.mplier = VW'(prod_reg[31:0]);
            end
            S_G_T:
            begin
                if (mul_prod <= rhs_w)
                begin
                    q_next = t_w;
                end
                bit_next = bit_reg - BITW'(1);
            end
            S_SM_MUL:
            begin
                op_a = $signed({2'b00, (q_reg > smooth_reg) ? attack_reg : release_reg});
                op_b = $signed({2'b00, q_reg}) - $signed({2'b00, smooth_reg});
            end
            S_SM_UPD:
            begin
                priority if (sum_w < 0)
                begin
                    smooth_next = '0;
                end
                else if (sum_w > $signed((2*SMW)'(ONE_Q15)))
                begin
                    smooth_next = 16'(ONE_Q15);
                end
                else
                begin
                    smooth_next = sum_w[15:0];
                end
            end
            S_OUT:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_valid_next            = 1'b1;
                    out_data_next.pump_level  = filled_reg ? smooth_reg : '0;
                    out_data_next.window_full = filled_reg;
                end
            end
            default:
            begin
                idx_next = idx_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            ret_reg       <= S_IDLE;
            slot_reg      <= '0;
            filled_reg    <= 1'b0;
            smooth_reg    <= '0;
            attack_reg    <= ATTACK_RESET;
            release_reg   <= RELEASE_RESET;
            idx_reg       <= '0;
            bit_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            ret_reg       <= ret_next;
            slot_reg      <= slot_next;
            filled_reg    <= filled_next;
            smooth_reg    <= smooth_next;
            attack_reg    <= attack_next;
            release_reg   <= release_next;
            idx_reg       <= idx_next;
            bit_reg       <= bit_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        sb_reg       <= sb_next;
        sm_reg       <= sm_next;
        sbb_reg      <= sbb_next;
        smm_reg      <= smm_next;
        sbm_reg      <= sbm_next;
        varb_reg     <= varb_next;
        varm_reg     <= varm_next;
        mag_reg      <= mag_next;
        d_reg        <= d_next;
        c_reg        <= c_next;
        q_reg        <= q_next;
        prod_reg     <= prod_next;
        out_data_reg <= out_data_next;
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule

FILE: rtl/pmp_checker.sv
// port-level checks for the pump detector, attached to the top level by bind
// depends on pmp_pkg and envelope_anticorrelation_pump_detector
module pmp_checker (
    input logic               clk,
    input logic               rst_n,
    input logic               in_valid,
    input logic               in_ready,
    input logic               out_valid,
    input logic               out_ready,
    input pmp_pkg::out_item_t out_data
);
    import pmp_pkg::*;

    // one request at a time
    a_busy_after_request: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("input ready right after a request");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_data))
        else $error("stalled result changed");

    a_zero_until_full: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_data.window_full |-> out_data.pump_level == 16'd0)
        else $error("level shown before window full");

    a_level_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> out_data.pump_level <= 16'(ONE_Q15))
        else $error("level above one");

endmodule

bind envelope_anticorrelation_pump_detector pmp_checker u_pmp_checker (.*);

FILE: tb/pump_level_checker.sv
// checker for the envelope anticorrelation pump detector: watches both channels and the
// register port, predicts each pump level from its own copy of the window and gains
// depends on pmp_pkg
module pump_level_checker (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    input  logic                          in_ready,
    input  pmp_pkg::in_item_t             in_data,
    input  logic                          out_valid,
    input  logic                          out_ready,
    input  pmp_pkg::out_item_t            out_data,
    input  logic                          cfg_write,
    input  logic [pmp_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [pmp_pkg::CFG_DW-1:0]    cfg_data,
    output int                            errors,
    output int                            waiting
);
    timeunit 1ns;
    timeprecision 1ps;
    import pmp_pkg::*;

    logic [15:0] bass_hist [WINDOW_LENGTH];
    logic [15:0] mid_hist [WINDOW_LENGTH];
    int          slot;
    logic        full;
    logic [31:0] level;
    logic [15:0] attack;
    logic [15:0] release_g;
    out_item_t   expected_levels [$];

    assign waiting = expected_levels.size();

    task automatic report(string what, int got, int want);
        $display("pump level mismatch on %s: got %0d, expected %0d at %0t", what, got, want,
                 $time);
        errors++;
    endtask

    function automatic logic [31:0] raw_level(logic [63:0] mag, logic [63:0] vb,
                                              logic [63:0] vm);
        logic [127:0] d;
        logic [127:0] c;
        logic [31:0]  lo;
        logic [31:0]  hi;
        logic [31:0]  q;
        d  = {64'd0, vb} * {64'd0, vm};
        c  = ({64'd0, mag} * {64'd0, mag}) << 30;
        lo = 0;
        hi = ONE_Q15;
        while (lo < hi)
        begin
            q = (lo + hi + 1) / 2;
            if (d * {96'd0, q * q} <= c)
                lo = q;
            else
                hi = q - 1;
        end
        return lo;
    endfunction

    function automatic out_item_t predict(in_item_t x);
        logic [63:0]        sb, sm, sbb, smm, sbm, vb, vm;
        logic signed [63:0] cov, diff, prod, nxt;
        logic [31:0]        raw;
        logic [15:0]        gain;
        out_item_t          r;
        sb = 0; sm = 0; sbb = 0; smm = 0; sbm = 0;
        bass_hist[slot] = x.bass_energy;
        mid_hist[slot]  = x.mid_energy;
        slot = (slot + 1) % WINDOW_LENGTH;
        if (slot == 0)
            full = 1'b1;
        if (full)
        begin
            for (int i = 0; i < WINDOW_LENGTH; i++)
            begin
                sb  += bass_hist[i];
                sm  += mid_hist[i];
                sbb += 64'(bass_hist[i]) * bass_hist[i];
                smm += 64'(mid_hist[i]) * mid_hist[i];
                sbm += 64'(bass_hist[i]) * mid_hist[i];
            end
            vb = WINDOW_LENGTH * sbb - sb * sb;
            vm = WINDOW_LENGTH * smm - sm * sm;
            if (vb != 0 && vm != 0)
            begin
                cov  = $signed(WINDOW_LENGTH * sbm) - $signed(sb * sm);
                raw  = (cov < 0) ? raw_level(-cov, vb, vm) : 0;
                gain = (raw > level) ? attack : release_g;
                diff = $signed({32'd0, raw}) - $signed({32'd0, level});
                prod = $signed({48'd0, gain}) * diff;
                nxt  = $signed({32'd0, level}) + (prod >>> Q_FRAC);
                if (nxt < 0)
                    nxt = 0;
                if (nxt > ONE_Q15)
                    nxt = ONE_Q15;
                level = nxt[31:0];
            end
        end
        r.pump_level  = full ? level[15:0] : 16'd0;
        r.window_full = full;
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        out_item_t want;
        if (!rst_n)
        begin
            slot      = 0;
            full      = 1'b0;
            level     = 0;
            attack    = ATTACK_RESET;
            release_g = RELEASE_RESET;
            errors    = 0;
            expected_levels.delete();
            for (int i = 0; i < WINDOW_LENGTH; i++)
            begin
                bass_hist[i] = 0;
                mid_hist[i]  = 0;
            end
        end
        else
        begin
            if (cfg_write)
            begin
                if (cfg_index == REG_ATTACK)
                    attack = cfg_data;
                else if (cfg_index == REG_RELEASE)
                    release_g = cfg_data;
            end
            if (in_valid && in_ready)
                expected_levels.push_back(predict(in_data));
            if (out_valid && out_ready)
            begin
                if (expected_levels.size() == 0)
                begin
                    $display("pump level with no request outstanding at %0t", $time);
                    errors++;
                end
                else
                begin
                    want = expected_levels.pop_front();
                    if (out_data.pump_level !== want.pump_level)
                        report("pump_level", out_data.pump_level, want.pump_level);
                    if (out_data.window_full !== want.window_full)
                        report("window_full", out_data.window_full, want.window_full);
                end
            end
        end
    end
endmodule

FILE: tb/envelope_anticorrelation_pump_detector_test.sv
// top of the pump detector testbench: clock, reset, requests, gain writes and verdict
// depends on pmp_pkg, the detector and pump_level_checker
module envelope_anticorrelation_pump_detector_test;
    timeunit 1ns;
    timeprecision 1ps;
    import pmp_pkg::*;

    localparam int STALL_LIMIT = 40000;

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 in_valid = 1'b0;
    logic                 in_ready;
    in_item_t             in_data = '0;
    logic                 out_valid;
    logic                 out_ready = 1'b0;
    out_item_t            out_data;
    logic                 cfg_write = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = REG_ATTACK;
    logic [CFG_DW-1:0]    cfg_data = '0;
    int                   errors;
    int                   waiting;
    int                   gap_pct = 0;
    int                   stall_pct = 0;
    int                   quiet = 0;

    envelope_anticorrelation_pump_detector dut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
        .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
        .cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    pump_level_checker u_checker (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
        .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
        .cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data),
        .errors(errors), .waiting(waiting)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    always @(posedge clk)
        out_ready <= ($urandom_range(99) >= stall_pct);

    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready))
            quiet <= 0;
        else
            quiet <= quiet + 1;
        if (quiet >= STALL_LIMIT)
        begin
            $display("envelope_anticorrelation_pump_detector_test: errors");
            $finish;
        end
    end

    task automatic send(logic [15:0] b, logic [15:0] m);
        if ($urandom_range(99) < gap_pct)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clk);
        end
        in_data  <= '{bass_energy: b, mid_energy: m};
        in_valid <= 1'b1;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
    endtask

    task automatic set_gains(logic [15:0] att, logic [15:0] rel);
        in_valid <= 1'b0;
        @(posedge clk);
        while (waiting != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
        cfg_write <= 1'b1;
        cfg_index <= REG_ATTACK;
        cfg_data  <= att;
        @(posedge clk);
        cfg_index <= REG_RELEASE;
        cfg_data  <= rel;
        @(posedge clk);
        cfg_write <= 1'b0;
        @(posedge clk);
    endtask

    task automatic random_burst(int count);
        int          mode;
        logic [15:0] b, m;
        for (int i = 0; i < count; i++)
        begin
            if (i % 16 == 0)
                mode = $urandom_range(9);
            b = 16'($urandom);
            if (mode < 5)
                m = 16'hffff - b + 16'($urandom_range(0, 2000));
            else if (mode < 7)
                m = 16'($urandom);
            else if (mode < 8)
            begin
                b = 16'd1234;
                m = 16'($urandom);
            end
            else
                m = b ^ 16'($urandom_range(0, 255));
            send(b, m);
        end
    endtask

    initial
    begin
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        // opposite extremes: perfect anticorrelation, then a flat window
        for (int i = 0; i < 66; i++)
            send((i % 2) ? 16'hffff : 16'h0000, (i % 2) ? 16'h0000 : 16'hffff);
        for (int i = 0; i < 66; i++)
            send(16'hffff, 16'hffff);
        set_gains(ATTACK_RESET, RELEASE_RESET);
        random_burst(200);
        set_gains(16'd32768, 16'd32768);
        gap_pct = 50;
        random_burst(260);
        set_gains(16'd0, 16'd0);
        gap_pct   = 0;
        stall_pct = 50;
        random_burst(200);
        set_gains(16'hffff, 16'hffff);
        gap_pct   = 29;
        stall_pct = 29;
        random_burst(260);
        set_gains(16'($urandom), 16'($urandom));
        gap_pct   = 0;
        stall_pct = 0;
        random_burst(200);
        set_gains(16'($urandom_range(0, 32768)), 16'($urandom_range(0, 32768)));
        random_burst(100);
        in_valid <= 1'b0;
        @(posedge clk);
        while (waiting != 0)
            @(posedge clk);
        repeat (50) @(posedge clk);
        if (errors == 0)
            $display("envelope_anticorrelation_pump_detector_test: clean");
        else
            $display("envelope_anticorrelation_pump_detector_test: errors");
        $finish;
    end
endmodule
